FILE: rtl/lcdnw_pkg.sv
// ----------------------------------------------------------------------------
// lcdnw_pkg
// Types and constants shared by the character LCD nibble write sequencer.
// ----------------------------------------------------------------------------
package lcdnw_pkg;

  localparam int TICK_W   = 20;
  localparam int CFG_IDX_W = 2;
  localparam int QDEPTH   = 2;

  // Request kinds.
  localparam logic [1:0] FUNC_INIT = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_CHAR = 2'd2;
  localparam logic [1:0] FUNC_GOTO = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_PULSE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_WAIT    = 2'd2;

  localparam logic [TICK_W-1:0] ENABLE_PULSE_RESET = 20'd1000;
  localparam logic [TICK_W-1:0] SETTLE_RESET       = 20'd5000;
  localparam logic [TICK_W-1:0] INIT_WAIT_RESET    = 20'd100000;

  // Cursor addressing bases for the two display lines.
  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;

  // Power-up command list.
  localparam logic [2:0] INIT_LAST_IDX = 3'd6;
  localparam logic [7:0] INIT_LAST_CMD = 8'h02;

  // Segments within one byte: setup high, pulse high, setup low, pulse low, settle.
  localparam logic [2:0] PHASE_SETTLE = 3'd4;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] byte_value;
    logic       row;
    logic [5:0] col;
  } req_t;

  typedef struct packed {
    logic              reg_select;
    logic              read_write;
    logic              enable;
    logic [3:0]        data_nibble;
    logic [TICK_W-1:0] hold_ticks;
    logic              last;
  } seg_t;

  // Classified request handed from the front to the back.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_value;
  } desc_t;

  typedef struct packed {
    logic [TICK_W-1:0] enable_pulse_ticks;
    logic [TICK_W-1:0] settle_ticks;
    logic [TICK_W-1:0] init_wait_ticks;
  } cfg_regs_t;

  function automatic logic [7:0] init_cmd(input logic [2:0] idx);
    logic [7:0] b;
    unique case (idx)
      3'd0:    b = 8'h33;
      3'd1:    b = 8'h32;
      3'd2:    b = 8'h28;
      3'd3:    b = 8'h0C;
      3'd4:    b = 8'h01;
      3'd5:    b = 8'h06;
      3'd6:    b = INIT_LAST_CMD;
      default: b = INIT_LAST_CMD;
    endcase
    return b;
  endfunction

endpackage

FILE: rtl/lcdnw_fifo.sv
// ----------------------------------------------------------------------------
// lcdnw_fifo
// Small first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module lcdnw_fifo import lcdnw_pkg::*; #(
  parameter int WIDTH = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] din,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] dout,
  output logic             empty
);

  localparam int PTR_W = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  logic [WIDTH-1:0] mem [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign full  = (count == CNT_W'(QDEPTH));
  assign empty = (count == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;
  assign dout  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wr_ptr] <= din;
    end
  end

endmodule

FILE: rtl/lcdnw_front.sv
// ----------------------------------------------------------------------------
// lcdnw_front
// Classifies a request into the byte to send, its RS level and whether it is
// the power-up init sequence.
// ----------------------------------------------------------------------------
module lcdnw_front import lcdnw_pkg::*; #(
  parameter int LINE_LENGTH = 40
) (
  input  req_t  req,
  output desc_t desc
);

  localparam logic [5:0] LAST_COL = 6'(LINE_LENGTH - 1);
  localparam logic [5:0] COL_LIMIT = 6'(LINE_LENGTH);

  logic [5:0] col_sat;
  logic [7:0] base;

  // Columns past the end of the line stick at the last column.
  assign col_sat = (req.col >= COL_LIMIT) ? LAST_COL : req.col;
  assign base    = req.row ? ROW1_BASE : ROW0_BASE;

  always_comb begin
    desc = '0;
    unique case (req.func)
      FUNC_INIT: begin
        desc.is_init = 1'b1;
      end
      FUNC_CMD: begin
        desc.byte_value = req.byte_value;
      end
      FUNC_CHAR: begin
        desc.rs         = 1'b1;
        desc.byte_value = req.byte_value;
      end
      FUNC_GOTO: begin
        desc.byte_value = base + {2'b00, col_sat};
      end
    endcase
  end

endmodule

FILE: rtl/lcdnw_back.sv
// ----------------------------------------------------------------------------
// lcdnw_back
// Segment sequencer: turns one classified request into its run of pin
// segments, one segment per cycle while the result queue has room.
// ----------------------------------------------------------------------------
module lcdnw_back import lcdnw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cfg_regs_t cfg,
  input  desc_t     q_desc,
  input  logic      q_empty,
  output logic      q_pop,
  output seg_t      seg,
  output logic      seg_valid,
  input  logic      out_full
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PRE  = 4'b0010,
    ST_BYTE = 4'b0100,
    ST_POST = 4'b1000
  } back_state_t;

  back_state_t state, state_next;
  logic [2:0]  phase, phase_next;
  logic [2:0]  cmd_idx, cmd_idx_next;
  desc_t       cur, cur_next;
  logic [7:0]  byte_cur;
  logic        emit;
  logic        seg_done;
  logic        load;

  assign byte_cur = cur.is_init ? init_cmd(cmd_idx) : cur.byte_value;

  always_comb begin
    seg = '0;
    unique case (state)
      ST_IDLE: begin
        seg = '0;
      end
      ST_PRE: begin
        seg.hold_ticks = cfg.init_wait_ticks;
      end
      ST_BYTE: begin
        seg.reg_select  = cur.rs;
        seg.enable      = phase[0];
        seg.data_nibble = (phase < 3'd2) ? byte_cur[7:4] : byte_cur[3:0];
        if (phase[0]) begin
          seg.hold_ticks = cfg.enable_pulse_ticks;
        end else if (phase == PHASE_SETTLE) begin
          seg.hold_ticks = cfg.settle_ticks;
          seg.last       = !cur.is_init;
        end
      end
      ST_POST: begin
        // The low nibble of the final init command is still on the bus.
        seg.data_nibble = INIT_LAST_CMD[3:0];
        seg.hold_ticks  = cfg.init_wait_ticks;
        seg.last        = 1'b1;
      end
    endcase
  end

  assign emit      = (state != ST_IDLE) && !out_full;
  assign seg_valid = emit;
  assign seg_done  = emit && seg.last;
  assign load      = ((state == ST_IDLE) || seg_done) && !q_empty;
  assign q_pop     = load;

  always_comb begin
    state_next   = state;
    phase_next   = phase;
    cmd_idx_next = cmd_idx;
    cur_next     = cur;
    if (load) begin
      state_next   = q_desc.is_init ? ST_PRE : ST_BYTE;
      phase_next   = '0;
      cmd_idx_next = '0;
      cur_next     = q_desc;
    end else if (seg_done) begin
      state_next = ST_IDLE;
    end else if (emit) begin
      unique case (state)
        ST_IDLE: begin
          state_next = ST_IDLE;
        end
        ST_PRE: begin
          state_next = ST_BYTE;
          phase_next = '0;
        end
        ST_BYTE: begin
          if (phase == PHASE_SETTLE) begin
            phase_next = '0;
            if (cmd_idx == INIT_LAST_IDX) begin
              state_next = ST_POST;
            end else begin
              cmd_idx_next = cmd_idx + 3'd1;
            end
          end else begin
            phase_next = phase + 3'd1;
          end
        end
        ST_POST: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      phase   <= '0;
      cmd_idx <= '0;
    end else begin
      state   <= state_next;
      phase   <= phase_next;
      cmd_idx <= cmd_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    cur <= cur_next;
  end

endmodule

FILE: rtl/char_lcd_nibble_write_sequencer.sv
// Path: a request passes through the request queue, the segment sequencer and the
// segment queue before its first segment is on the result ports.
// Throughput: one segment per cycle while the segment queue has room, set by
// the segment sequencer. A byte request is 5 segments; power-up init is 37.
// Reset: synchronous; both queues empty, sequencer idle, timing registers at
// their defaults (1000, 5000, 100000 ticks).
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Turns character LCD requests into timed pin segments for a 4-bit bus.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer import lcdnw_pkg::*; #(
  parameter int LINE_LENGTH = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  req_t                 req,
  output logic                 empty,
  input  logic                 pop,
  output seg_t                 seg,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data
);

  cfg_regs_t cfg;
  desc_t     desc;
  desc_t     q_desc;
  logic      q_empty;
  logic      q_pop;
  seg_t      back_seg;
  logic      back_valid;
  logic      out_full;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable_pulse_ticks <= ENABLE_PULSE_RESET;
      cfg.settle_ticks       <= SETTLE_RESET;
      cfg.init_wait_ticks    <= INIT_WAIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ENABLE_PULSE: cfg.enable_pulse_ticks <= cfg_data;
        CFG_SETTLE:       cfg.settle_ticks       <= cfg_data;
        CFG_INIT_WAIT:    cfg.init_wait_ticks    <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  lcdnw_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .req  (req),
    .desc (desc)
  );

  lcdnw_fifo #(
    .WIDTH($bits(desc_t))
  ) u_req_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (push),
    .din   (desc),
    .full  (full),
    .rd_en (q_pop),
    .dout  (q_desc),
    .empty (q_empty)
  );

  lcdnw_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_desc    (q_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .seg       (back_seg),
    .seg_valid (back_valid),
    .out_full  (out_full)
  );

  lcdnw_fifo #(
    .WIDTH($bits(seg_t))
  ) u_seg_q (
    .clk   (clk),
    .rst   (rst),
    .wr_en (back_valid),
    .din   (back_seg),
    .full  (out_full),
    .rd_en (pop),
    .dout  (seg),
    .empty (empty)
  );

endmodule

FILE: rtl/lcdnw_checker.sv
// ----------------------------------------------------------------------------
// lcdnw_assertions
// Port-level checks for the character LCD write sequencer.
// ----------------------------------------------------------------------------
module lcdnw_assertions import lcdnw_pkg::*; (
  input logic clk,
  input logic rst,
  input logic full,
  input logic empty,
  input logic pop,
  input seg_t seg
);

  // Reset leaves both queues empty.
  a_reset_clear: assert property (@(posedge clk) rst |=> !full && empty)
    else $error("queues not empty after reset");

  // A waiting segment holds until its beat is taken.
  a_seg_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(seg))
    else $error("waiting segment changed");

  a_write_only: assert property (@(posedge clk) disable iff (rst)
    !empty |-> !seg.read_write)
    else $error("read_write driven high");

  // Every request ends with E low, so an E pulse is never the last segment.
  a_last_e_low: assert property (@(posedge clk) disable iff (rst)
    !empty && seg.last |-> !seg.enable)
    else $error("request ended with E high");

endmodule

bind char_lcd_nibble_write_sequencer lcdnw_assertions u_lcdnw_checker (
  .clk   (clk),
  .rst   (rst),
  .full  (full),
  .empty (empty),
  .pop   (pop),
  .seg   (seg)
);

FILE: verif/lcdnw_checker.sv
// ----------------------------------------------------------------------------
// lcdnw_checker
// Watches the request, segment and timing-register channels of the LCD
// nibble write sequencer. It builds the expected pin segments for every
// accepted request and compares each popped segment with the oldest one.
// ----------------------------------------------------------------------------
module lcdnw_checker import lcdnw_pkg::*; #(
  parameter int LINE_LENGTH = 40
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic                 full,
  input  req_t                 req,
  input  logic                 empty,
  input  logic                 pop,
  input  seg_t                 seg,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TICK_W-1:0]    cfg_data,
  output int                   segs_pending,
  output int                   fail_count,
  output int                   reqs_taken,
  output int                   inits_taken,
  output int                   segs_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  // Power-up command bytes, first one in the top byte.
  localparam logic [55:0] POWER_UP_SEQ = 56'h33_32_28_0C_01_06_02;

  cfg_regs_t timing;
  seg_t      expected_segs[$];
  seg_t      want;

  initial begin
    segs_pending = 0;
    fail_count   = 0;
    reqs_taken   = 0;
    inits_taken  = 0;
    segs_checked = 0;
  end

  task automatic add_seg(input logic rs, input logic en, input logic [3:0] nib,
                         input logic [TICK_W-1:0] hold, input logic fin);
    seg_t s;
    s.reg_select  = rs;
    s.read_write  = 1'b0;
    s.enable      = en;
    s.data_nibble = nib;
    s.hold_ticks  = hold;
    s.last        = fin;
    expected_segs.push_back(s);
  endtask

  task automatic add_byte(input logic rs, input logic [7:0] b, input logic fin);
    add_seg(rs, 1'b0, b[7:4], '0, 1'b0);
    add_seg(rs, 1'b1, b[7:4], timing.enable_pulse_ticks, 1'b0);
    add_seg(rs, 1'b0, b[3:0], '0, 1'b0);
    add_seg(rs, 1'b1, b[3:0], timing.enable_pulse_ticks, 1'b0);
    add_seg(rs, 1'b0, b[3:0], timing.settle_ticks, fin);
  endtask

  task automatic plan_request(input req_t r);
    logic [5:0] c;
    logic [7:0] addr;
    case (r.func)
      FUNC_INIT: begin
        add_seg(1'b0, 1'b0, 4'h0, timing.init_wait_ticks, 1'b0);
        for (int i = 0; i < 7; i++) begin
          add_byte(1'b0, POWER_UP_SEQ[8*(6-i) +: 8], 1'b0);
        end
        // The low nibble of the final command stays on the bus while idling.
        add_seg(1'b0, 1'b0, POWER_UP_SEQ[3:0], timing.init_wait_ticks, 1'b1);
      end
      FUNC_CMD:  add_byte(1'b0, r.byte_value, 1'b1);
      FUNC_CHAR: add_byte(1'b1, r.byte_value, 1'b1);
      default: begin
        c    = (r.col >= LINE_LENGTH) ? 6'(LINE_LENGTH - 1) : r.col;
        addr = (r.row ? ROW1_BASE : ROW0_BASE) + {2'b00, c};
        add_byte(1'b0, addr, 1'b1);
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      timing.enable_pulse_ticks = ENABLE_PULSE_RESET;
      timing.settle_ticks       = SETTLE_RESET;
      timing.init_wait_ticks    = INIT_WAIT_RESET;
      expected_segs.delete();
    end else begin
      if (pop && !empty) begin
        if (expected_segs.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("%0t checker: segment beat with nothing expected: rs=%0b rw=%0b e=%0b",
                     $time, seg.reg_select, seg.read_write, seg.enable,
                     " d=%h hold=%0d last=%0b", seg.data_nibble, seg.hold_ticks, seg.last);
          end
        end else begin
          want = expected_segs.pop_front();
          segs_checked++;
          if (seg.reg_select !== want.reg_select || seg.read_write !== want.read_write ||
              seg.enable !== want.enable || seg.data_nibble !== want.data_nibble ||
              seg.hold_ticks !== want.hold_ticks || seg.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("%0t checker: segment %0d mismatch", $time, segs_checked);
              $display("  expected rs=%0b rw=%0b e=%0b d=%h hold=%0d last=%0b",
                       want.reg_select, want.read_write, want.enable,
                       want.data_nibble, want.hold_ticks, want.last);
              $display("  actual   rs=%0b rw=%0b e=%0b d=%h hold=%0d last=%0b",
                       seg.reg_select, seg.read_write, seg.enable,
                       seg.data_nibble, seg.hold_ticks, seg.last);
            end
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENABLE_PULSE: timing.enable_pulse_ticks = cfg_data;
          CFG_SETTLE:       timing.settle_ticks       = cfg_data;
          CFG_INIT_WAIT:    timing.init_wait_ticks    = cfg_data;
          default: ;
        endcase
      end
      if (push && !full) begin
        reqs_taken++;
        if (req.func == FUNC_INIT) inits_taken++;
        plan_request(req);
      end
    end
    segs_pending <= expected_segs.size();
  end

endmodule

FILE: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Top of the LCD nibble write sequencer testbench. Sends directed and random
// requests in bursts under several timing-register settings, pops segments on
// a changing stall pattern, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb import lcdnw_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINE_LEN = 40;
  // Index past the register list; writes to it must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 push      = 1'b0;
  logic                 full;
  req_t                 req       = '0;
  logic                 empty;
  logic                 pop       = 1'b0;
  seg_t                 seg;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TICK_W-1:0]    cfg_data  = '0;

  int segs_pending;
  int fail_count;
  int reqs_taken;
  int inits_taken;
  int segs_checked;

  req_t       outbox[$];
  logic [7:0] pop_phase  = '0;
  int         stall_left = 0;

  char_lcd_nibble_write_sequencer #(.LINE_LENGTH(LINE_LEN)) u_dut (
    .clk, .rst, .push, .full, .req, .empty, .pop, .seg,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  lcdnw_checker #(.LINE_LENGTH(LINE_LEN)) u_checker (
    .clk, .rst, .push, .full, .req, .empty, .pop, .seg,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .segs_pending, .fail_count, .reqs_taken, .inits_taken, .segs_checked
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver: the stall pattern changes with the top two bits of pop_phase.
  always @(posedge clk) begin
    if (rst) begin
      pop        <= 1'b0;
      pop_phase  <= '0;
      stall_left <= 0;
    end else begin
      pop_phase <= pop_phase + 8'd1;
      case (pop_phase[7:6])
        2'd0: pop <= 1'b1;
        2'd1: pop <= 1'($urandom_range(0, 1));
        2'd2: pop <= (pop_phase[1:0] == 2'b00);
        default: begin
          if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            pop        <= 1'b0;
          end else begin
            stall_left <= $urandom_range(0, 16);
            pop        <= 1'b1;
          end
        end
      endcase
    end
  end

  function automatic req_t make_req(input logic [1:0] f, input logic [7:0] b,
                                    input logic r, input logic [5:0] c);
    req_t q;
    q.func       = f;
    q.byte_value = b;
    q.row        = r;
    q.col        = c;
    return q;
  endfunction

  function automatic req_t rand_req();
    req_t q;
    q.byte_value = 8'($urandom);
    q.row        = 1'($urandom);
    // Mostly columns on the line, some past its end.
    q.col        = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, LINE_LEN - 1))
                                                 : 6'($urandom_range(LINE_LEN, 63));
    if ($urandom_range(0, 99) < 6) begin
      q.func = FUNC_INIT;
    end else begin
      q.func = 2'($urandom_range(1, 3));
    end
    return q;
  endfunction

  task automatic queue_random(input int n);
    for (int i = 0; i < n; i++) begin
      outbox.push_back(rand_req());
    end
  endtask

  // One request beat; push stays high on return so a burst continues.
  task automatic drive_req(input req_t q);
    push <= 1'b1;
    req  <= q;
    do @(posedge clk); while (full);
  endtask

  task automatic send_outbox();
    int burst;
    int gap;
    while (outbox.size() != 0) begin
      burst = $urandom_range(1, 16);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      for (int k = 0; k < burst && outbox.size() != 0; k++) begin
        drive_req(outbox.pop_front());
      end
      if (gap != 0 && outbox.size() != 0) begin
        push <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    push <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk); while (segs_pending != 0);
  endtask

  task automatic set_timing(input logic [TICK_W-1:0] pulse, input logic [TICK_W-1:0] settle,
                            input logic [TICK_W-1:0] hold_off, input bit poke_unused);
    logic [CFG_IDX_W-1:0] idx[4];
    logic [TICK_W-1:0]    val[4];
    idx[0] = CFG_UNUSED;
    val[0] = 20'($urandom);
    idx[1] = CFG_ENABLE_PULSE;
    val[1] = pulse;
    idx[2] = CFG_SETTLE;
    val[2] = settle;
    idx[3] = CFG_INIT_WAIT;
    val[3] = hold_off;
    for (int i = poke_unused ? 0 : 1; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed requests at the reset timing.
    outbox.push_back(make_req(FUNC_INIT, 8'hFF, 1'b1, 6'd63));
    outbox.push_back(make_req(FUNC_CMD,  8'h00, 1'b0, 6'd0));
    outbox.push_back(make_req(FUNC_CMD,  8'hFF, 1'b1, 6'd63));
    outbox.push_back(make_req(FUNC_CMD,  8'h5A, 1'b0, 6'd21));
    outbox.push_back(make_req(FUNC_CHAR, 8'h00, 1'b1, 6'd42));
    outbox.push_back(make_req(FUNC_CHAR, 8'hFF, 1'b0, 6'd0));
    outbox.push_back(make_req(FUNC_CHAR, 8'hA5, 1'b1, 6'd7));
    outbox.push_back(make_req(FUNC_CHAR, 8'h41, 1'b0, 6'd63));
    outbox.push_back(make_req(FUNC_GOTO, 8'hFF, 1'b0, 6'd0));
    outbox.push_back(make_req(FUNC_GOTO, 8'h00, 1'b0, 6'd39));
    outbox.push_back(make_req(FUNC_GOTO, 8'h3C, 1'b1, 6'd0));
    outbox.push_back(make_req(FUNC_GOTO, 8'hC3, 1'b1, 6'd39));
    outbox.push_back(make_req(FUNC_GOTO, 8'h00, 1'b0, 6'd40));
    outbox.push_back(make_req(FUNC_GOTO, 8'h00, 1'b1, 6'd40));
    outbox.push_back(make_req(FUNC_GOTO, 8'hFF, 1'b0, 6'd63));
    outbox.push_back(make_req(FUNC_GOTO, 8'hFF, 1'b1, 6'd63));
    outbox.push_back(make_req(FUNC_GOTO, 8'h12, 1'b1, 6'd42));
    outbox.push_back(make_req(FUNC_INIT, 8'h00, 1'b0, 6'd0));
    send_outbox();

    // Zero pulse width and zero waits, with a write to the unused index.
    drain();
    set_timing(20'd0, 20'd0, 20'd0, 1'b1);
    outbox.push_back(make_req(FUNC_INIT, 8'h00, 1'b0, 6'd0));
    queue_random(60);
    send_outbox();

    drain();
    set_timing('1, '1, '1, 1'b0);
    outbox.push_back(make_req(FUNC_INIT, 8'hFF, 1'b1, 6'd63));
    queue_random(60);
    send_outbox();

    drain();
    set_timing(20'd1, 20'($urandom), 20'($urandom), 1'b1);
    queue_random(70);
    send_outbox();

    drain();
    set_timing(20'($urandom_range(1, 20'hFFFFF)), 20'($urandom), 20'($urandom), 1'b0);
    queue_random(70);
    send_outbox();

    drain();
    set_timing(ENABLE_PULSE_RESET, SETTLE_RESET, INIT_WAIT_RESET, 1'b0);
    queue_random(60);
    send_outbox();

    drain();
    // Anything that pops out now was never requested.
    repeat (40) @(posedge clk);
    @(negedge clk);
    $display("tb: %0d requests (%0d power-up inits), %0d segments compared",
             reqs_taken, inits_taken, segs_checked);
    $display("tb: timing registers swept from zero to full scale with bursty traffic");
    if (fail_count == 0 && segs_pending == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("tb: timeout with %0d segments outstanding", segs_pending);
    $display("tb: FAIL");
    $finish;
  end

endmodule

FILE: sim.f
rtl/lcdnw_pkg.sv
rtl/lcdnw_fifo.sv
rtl/lcdnw_front.sv
rtl/lcdnw_back.sv
rtl/char_lcd_nibble_write_sequencer.sv
rtl/lcdnw_checker.sv
verif/lcdnw_checker.sv
verif/tb.sv
